>>> rtl/lhi_pkg.sv
// shared types, constants and helpers for the leg joint hold interlock
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lhi_pkg;

    localparam int JOINT_COUNT = 4;
    localparam int JIDX_W      = 2;
    localparam int ANGLE_W     = 24;
    localparam int SPEED_W     = 16;
    localparam int RATING_W    = 16;
    localparam int TORQUE_W    = 16;
    localparam int ERR_W       = ANGLE_W + 1;
    localparam int LIM_W       = 16;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_REF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_REF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIM   = 3'd7;

    // switch positions
    localparam logic [1:0] SW_MIDDLE = 2'd1;
    localparam logic [1:0] SW_DOWN   = 2'd2;

    // hold states
    localparam logic [1:0] HOLD_IDLE    = 2'd0;
    localparam logic [1:0] HOLD_ENABLED = 2'd1;
    localparam logic [1:0] HOLD_HOLDING = 2'd2;

    typedef struct packed {
        logic [47:0] left_ref;
        logic [47:0] right_ref;
        logic [15:0] kp;
        logic [15:0] kd;
        logic [14:0] hold_limit;
        logic [22:0] window;
        logic [14:0] speed_limit;
        logic [22:0] step_limit;
    } t_cfg;

    // one joint's work for the torque stage
    typedef struct packed {
        logic [JIDX_W-1:0]  joint;
        logic [ERR_W-1:0]   err;
        logic [SPEED_W-1:0] speed;
        logic [LIM_W-1:0]   lim;
        logic [1:0]         hold;
        logic               en;
        logic               last;
    } t_entry;

    function automatic logic [ANGLE_W-1:0] ref_angle(t_cfg c, logic [JIDX_W-1:0] j);
        logic [ANGLE_W-1:0] r;
        case (j)
            2'd0:    r = c.left_ref[23:0];
            2'd1:    r = c.left_ref[47:24];
            2'd2:    r = c.right_ref[23:0];
            2'd3:    r = c.right_ref[47:24];
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/lhi_cfg.sv
// configuration register file of the interlock
// depends on lhi_pkg for register indexes and the t_cfg struct
`timescale 1ns / 1ps

module lhi_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lhi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lhi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lhi_pkg::t_cfg                  o_cfg
);
    import lhi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_ref    <= '0;
            r_cfg.right_ref   <= '0;
            r_cfg.kp          <= 16'd1024;
            r_cfg.kd          <= 16'd64;
            r_cfg.hold_limit  <= 15'd512;
            r_cfg.window      <= 23'd205;
            r_cfg.speed_limit <= 15'd102;
            r_cfg.step_limit  <= 23'd164;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEFT_REF:   r_cfg.left_ref    <= i_cfg_data;
                CFG_RIGHT_REF:  r_cfg.right_ref   <= i_cfg_data;
                CFG_KP:         r_cfg.kp          <= i_cfg_data[15:0];
                CFG_KD:         r_cfg.kd          <= i_cfg_data[15:0];
                CFG_HOLD_LIMIT: r_cfg.hold_limit  <= i_cfg_data[14:0];
                CFG_WINDOW:     r_cfg.window      <= i_cfg_data[22:0];
                CFG_SPEED_LIM:  r_cfg.speed_limit <= i_cfg_data[14:0];
                CFG_STEP_LIM:   r_cfg.step_limit  <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/lhi_front.sv
// front end: sample capture, arming logic, per-joint checks, work dispatch
// depends on lhi_pkg; feeds lhi_queue with one t_entry per joint
`timescale 1ns / 1ps

module lhi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lhi_pkg::t_cfg                 i_cfg,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [lhi_pkg::JIDX_W-1:0]    i_joint_index,
    input  logic [lhi_pkg::ANGLE_W-1:0]   i_joint_angle,
    input  logic [lhi_pkg::SPEED_W-1:0]   i_joint_speed,
    input  logic [lhi_pkg::RATING_W-1:0]  i_torque_rating,
    input  logic                          i_joint_fault,
    input  logic                          i_joint_running,
    input  logic [1:0]                    i_left_switch,
    input  logic [1:0]                    i_right_switch,
    input  logic                          i_receiver_fresh,
    input  logic                          i_feedback_fresh,
    output logic                          o_q_push,
    output lhi_pkg::t_entry               o_q_entry,
    input  logic                          i_q_full
);
    import lhi_pkg::*;

    localparam logic [1:0] F_IN    = 2'd0;
    localparam logic [1:0] F_CHECK = 2'd1;
    localparam logic [1:0] F_EMIT  = 2'd2;

    localparam logic [JIDX_W-1:0] LAST_J = JIDX_W'(JOINT_COUNT - 1);

    logic [1:0]          r_state;
    logic [JIDX_W-1:0]   r_idx;
    logic                r_armed;
    logic                r_prev_valid;
    logic                r_all_run;
    logic                r_en;
    logic [1:0]          r_hold;

    logic [ANGLE_W-1:0]  r_smp_angle  [JOINT_COUNT];
    logic [SPEED_W-1:0]  r_smp_speed  [JOINT_COUNT];
    logic [RATING_W-1:0] r_smp_rating [JOINT_COUNT];
    logic [1:0]          r_smp_flags  [JOINT_COUNT];
    logic [ANGLE_W-1:0]  r_prev_angle [JOINT_COUNT];

    logic               w_acc;
    logic               w_close;
    logic               w_down;
    logic               w_middle;
    logic [ANGLE_W-1:0] w_a;
    logic [ANGLE_W-1:0] w_ref;
    logic [ANGLE_W-1:0] w_prev;
    logic [SPEED_W-1:0] w_spd;
    logic [ERR_W-1:0]   w_diff_ref;
    logic [ERR_W-1:0]   w_diff_prev;
    logic [ERR_W-1:0]   w_mag_ref;
    logic [ERR_W-1:0]   w_mag_prev;
    logic [SPEED_W-1:0] w_mag_spd;
    logic               w_bad;
    logic               w_pass;
    logic [LIM_W-1:0]   w_lim;

    assign o_full   = (r_state != F_IN);
    assign w_acc    = i_push && (r_state == F_IN);
    assign w_close  = w_acc && (i_joint_index == LAST_J);
    assign w_down   = (i_left_switch == SW_DOWN) && (i_right_switch == SW_DOWN);
    assign w_middle = (i_left_switch == SW_MIDDLE) && (i_right_switch == SW_MIDDLE);

    assign w_a    = r_smp_angle[r_idx];
    assign w_ref  = ref_angle(i_cfg, r_idx);
    assign w_prev = r_prev_angle[r_idx];
    assign w_spd  = r_smp_speed[r_idx];

    assign w_diff_ref  = {w_a[ANGLE_W-1], w_a} - {w_ref[ANGLE_W-1], w_ref};
    assign w_diff_prev = {w_a[ANGLE_W-1], w_a} - {w_prev[ANGLE_W-1], w_prev};
    assign w_mag_ref   = w_diff_ref[ERR_W-1] ? -w_diff_ref : w_diff_ref;
    assign w_mag_prev  = w_diff_prev[ERR_W-1] ? -w_diff_prev : w_diff_prev;
    assign w_mag_spd   = w_spd[SPEED_W-1] ? -w_spd : w_spd;

    assign w_bad = (r_smp_rating[r_idx] == '0) || r_smp_flags[r_idx][0]
        || (w_mag_ref > {2'b00, i_cfg.window})
        || (r_prev_valid && (w_mag_prev > {2'b00, i_cfg.step_limit}))
        || (w_mag_spd > {1'b0, i_cfg.speed_limit});
    assign w_pass = (r_state == F_CHECK) && !w_bad && (r_idx == LAST_J);

    assign w_lim = (r_smp_rating[r_idx] < {1'b0, i_cfg.hold_limit})
        ? r_smp_rating[r_idx] : {1'b0, i_cfg.hold_limit};

    assign o_q_push        = (r_state == F_EMIT) && !i_q_full;
    assign o_q_entry.joint = r_idx;
    assign o_q_entry.err   = {w_ref[ANGLE_W-1], w_ref} - {w_a[ANGLE_W-1], w_a};
    assign o_q_entry.speed = w_spd;
    assign o_q_entry.lim   = w_lim;
    assign o_q_entry.hold  = r_hold;
    assign o_q_entry.en    = r_en;
    assign o_q_entry.last  = (r_idx == LAST_J);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IN;
            r_idx        <= '0;
            r_armed      <= 1'b0;
            r_prev_valid <= 1'b0;
            r_all_run    <= 1'b0;
            r_en         <= 1'b0;
            r_hold       <= HOLD_IDLE;
        end else begin
            unique case (r_state)
                F_IN: begin
                    if (w_close) begin
                        r_idx <= '0;
                        if (w_down) begin
                            r_armed      <= i_receiver_fresh;
                            r_prev_valid <= 1'b0;
                            r_en         <= 1'b0;
                            r_hold       <= HOLD_IDLE;
                            r_state      <= F_EMIT;
                        end else if (!r_armed || !w_middle || !i_receiver_fresh
                                     || !i_feedback_fresh) begin
                            r_armed      <= 1'b0;
                            r_prev_valid <= 1'b0;
                            r_en         <= 1'b0;
                            r_hold       <= HOLD_IDLE;
                            r_state      <= F_EMIT;
                        end else begin
                            r_all_run <= 1'b1;
                            r_state   <= F_CHECK;
                        end
                    end
                end
                F_CHECK: begin
                    if (w_bad) begin
                        r_armed      <= 1'b0;
                        r_prev_valid <= 1'b0;
                        r_en         <= 1'b0;
                        r_hold       <= HOLD_IDLE;
                        r_idx        <= '0;
                        r_state      <= F_EMIT;
                    end else if (r_idx == LAST_J) begin
                        r_prev_valid <= 1'b1;
                        r_en         <= 1'b1;
                        r_hold       <= (r_all_run && r_smp_flags[r_idx][1])
                            ? HOLD_HOLDING : HOLD_ENABLED;
                        r_idx        <= '0;
                        r_state      <= F_EMIT;
                    end else begin
                        r_all_run <= r_all_run && r_smp_flags[r_idx][1];
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                F_EMIT: begin
                    if (o_q_push) begin
                        if (r_idx == LAST_J) begin
                            r_state <= F_IN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= F_IN;
            endcase
        end
    end

    // sample store and last accepted angles
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_smp_angle[i_joint_index]  <= i_joint_angle;
            r_smp_speed[i_joint_index]  <= i_joint_speed;
            r_smp_rating[i_joint_index] <= i_torque_rating;
            r_smp_flags[i_joint_index]  <= {i_joint_running, i_joint_fault};
        end
        if (w_pass) begin
            for (int k = 0; k < JOINT_COUNT; k++) begin
                r_prev_angle[k] <= r_smp_angle[k];
            end
        end
    end

`ifndef SYNTHESIS
    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> o_full)
        else $error("closing transaction did not stall the input");
    a_prev_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_prev_valid) |-> $past(r_state) == F_CHECK)
        else $error("previous angles marked valid outside the check pass");
    a_arm_on_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_armed) |-> $past(w_close && w_down && i_receiver_fresh))
        else $error("armed without both switches down");
    a_hold_needs_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push && (o_q_entry.hold != HOLD_IDLE) |-> o_q_entry.en)
        else $error("active hold state dispatched without enable");
`endif

endmodule

>>> rtl/lhi_queue.sv
// short fifo of per-joint work between the front and the torque stage
// depends on lhi_pkg for t_entry and the queue depth
`timescale 1ns / 1ps

module lhi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lhi_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output lhi_pkg::t_entry o_entry,
    output logic            o_empty
);
    import lhi_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_PTR_W:0]   r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_entry   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) r_wptr <= r_wptr + 1'b1;
            if (w_do_pop)  r_rptr <= r_rptr + 1'b1;
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wptr] <= i_entry;
    end

endmodule

>>> rtl/lhi_back.sv
// back end: pd torque in two stages, round, clamp, and the result register
// depends on lhi_pkg; drains lhi_queue
`timescale 1ns / 1ps

module lhi_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lhi_pkg::t_cfg                 i_cfg,
    input  lhi_pkg::t_entry               i_entry,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [lhi_pkg::JIDX_W-1:0]    o_out_joint,
    output logic [lhi_pkg::TORQUE_W-1:0]  o_torque_command,
    output logic                          o_drive_enable,
    output logic [1:0]                    o_hold_state,
    output logic                          o_last_of_tick
);
    import lhi_pkg::*;

    localparam int P_W  = ERR_W + 17;
    localparam int D_W  = SPEED_W + 17;
    localparam int PD_W = P_W + 1;
    localparam int T_W  = PD_W - 10;

    logic                 r_s1_v;
    t_entry               r_s1;
    logic signed [P_W-1:0] r_p;
    logic signed [D_W-1:0] r_d;

    logic                  r_o_v;
    logic [JIDX_W-1:0]     r_o_joint;
    logic [TORQUE_W-1:0]   r_o_torque;
    logic                  r_o_en;
    logic [1:0]            r_o_hold;
    logic                  r_o_last;

    logic                   w_out_take;
    logic                   w_o_adv;
    logic signed [PD_W-1:0] w_pd;
    logic signed [T_W-1:0]  w_t;
    logic signed [T_W-1:0]  w_lim;
    logic signed [T_W-1:0]  w_clamped;

    assign w_out_take = i_pop && r_o_v;
    assign w_o_adv    = r_s1_v && (!r_o_v || w_out_take);
    assign o_q_pop    = !i_q_empty && (!r_s1_v || w_o_adv);

    // kp*err - 16*kd*speed + half lsb, then floor to q.10
    assign w_pd = PD_W'(r_p) - (PD_W'(r_d) <<< 4) + PD_W'(512);
    assign w_t  = w_pd[PD_W-1:10];
    assign w_lim = $signed({{(T_W - LIM_W){1'b0}}, r_s1.lim});
    always_comb begin
        if (w_t > w_lim) begin
            w_clamped = w_lim;
        end else if (w_t < -w_lim) begin
            w_clamped = -w_lim;
        end else begin
            w_clamped = w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_s1_v <= 1'b1;
            end else if (w_o_adv) begin
                r_s1_v <= 1'b0;
            end
            if (w_o_adv) begin
                r_o_v <= 1'b1;
            end else if (w_out_take) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1 <= i_entry;
            r_p  <= $signed({1'b0, i_cfg.kp}) * $signed(i_entry.err);
            r_d  <= $signed({1'b0, i_cfg.kd}) * $signed(i_entry.speed);
        end
        if (w_o_adv) begin
            r_o_joint  <= r_s1.joint;
            r_o_torque <= (r_s1.hold == HOLD_HOLDING) ? w_clamped[TORQUE_W-1:0] : '0;
            r_o_en     <= r_s1.en;
            r_o_hold   <= r_s1.hold;
            r_o_last   <= r_s1.last;
        end
    end

    assign o_empty          = !r_o_v;
    assign o_out_joint      = r_o_joint;
    assign o_torque_command = r_o_torque;
    assign o_drive_enable   = r_o_en;
    assign o_hold_state     = r_o_hold;
    assign o_last_of_tick   = r_o_last;

endmodule

>>> rtl/leg_joint_hold_interlock_top.sv
// top level of the leg joint hold interlock
// depends on lhi_pkg, lhi_cfg, lhi_front, lhi_queue and lhi_back
`timescale 1ns / 1ps

// usage:
// input channel: drive push with one joint sample; a transaction completes when
//   push is high and full is low. samples come in joint order 0..3, joint 3
//   closes the tick.
// result channel: while empty is low the oldest result is on the o_ ports;
//   pop high with empty low takes it. a closing transaction yields four
//   results, joint 0 first, last_of_tick set on joint 3.
// config: i_cfg_we with i_cfg_index and i_cfg_data writes one register at the
//   clock edge; write only while the block is idle.
// closing: a non-closing sample never raises full. a closing sample holds
//   full while the front checks the joints, one joint per cycle, up to the
//   first bad one, when armed with both switches middle and both links fresh,
//   then while it dispatches the four work entries into the work queue.
// pipeline: a queued entry passes the stage-one register, then the result
//   register; with pop high the two-stage pipeline gives one result per cycle.
// reset: i_rst_n low at a clock edge clears arming, previous-angle validity, queue
//   and result register and loads the register defaults.
// stall: when pop stays low, results back up into the 4-entry queue and the
//   front holds full until there is room again.

module leg_joint_hold_interlock_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lhi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lhi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [lhi_pkg::JIDX_W-1:0]    i_joint_index,
    input  logic [lhi_pkg::ANGLE_W-1:0]   i_joint_angle,
    input  logic [lhi_pkg::SPEED_W-1:0]   i_joint_speed,
    input  logic [lhi_pkg::RATING_W-1:0]  i_torque_rating,
    input  logic                          i_joint_fault,
    input  logic                          i_joint_running,
    input  logic [1:0]                    i_left_switch,
    input  logic [1:0]                    i_right_switch,
    input  logic                          i_receiver_fresh,
    input  logic                          i_feedback_fresh,
    output logic                          empty,
    input  logic                          pop,
    output logic [lhi_pkg::JIDX_W-1:0]    o_out_joint,
    output logic signed [lhi_pkg::TORQUE_W-1:0] o_torque_command,
    output logic                          o_drive_enable,
    output logic [1:0]                    o_hold_state,
    output logic                          o_last_of_tick
);
    import lhi_pkg::*;

    t_cfg   w_cfg;
    t_entry w_push_entry;
    t_entry w_pop_entry;
    logic   w_q_push;
    logic   w_q_full;
    logic   w_q_pop;
    logic   w_q_empty;
    logic [TORQUE_W-1:0] w_torque;

    lhi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lhi_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_push           (push),
        .o_full           (full),
        .i_joint_index    (i_joint_index),
        .i_joint_angle    (i_joint_angle),
        .i_joint_speed    (i_joint_speed),
        .i_torque_rating  (i_torque_rating),
        .i_joint_fault    (i_joint_fault),
        .i_joint_running  (i_joint_running),
        .i_left_switch    (i_left_switch),
        .i_right_switch   (i_right_switch),
        .i_receiver_fresh (i_receiver_fresh),
        .i_feedback_fresh (i_feedback_fresh),
        .o_q_push         (w_q_push),
        .o_q_entry        (w_push_entry),
        .i_q_full         (w_q_full)
    );

    lhi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_push_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_entry (w_pop_entry),
        .o_empty (w_q_empty)
    );

    lhi_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_entry          (w_pop_entry),
        .i_q_empty        (w_q_empty),
        .o_q_pop          (w_q_pop),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_out_joint      (o_out_joint),
        .o_torque_command (w_torque),
        .o_drive_enable   (o_drive_enable),
        .o_hold_state     (o_hold_state),
        .o_last_of_tick   (o_last_of_tick)
    );

    assign o_torque_command = $signed(w_torque);

endmodule

>>> verif/tb_top.sv
// testbench for the leg joint hold interlock: directed ticks, then random ticks under
// several register settings, every result checked against an in-bench torque predictor
// depends on lhi_pkg and leg_joint_hold_interlock_top
`timescale 1ns / 1ps

module tb_top;

    import lhi_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 5000;

    typedef struct {
        logic [JIDX_W-1:0]          joint;
        logic signed [ANGLE_W-1:0]  angle;
        logic signed [SPEED_W-1:0]  speed;
        logic [RATING_W-1:0]        rating;
        logic                       fault;
        logic                       running;
        logic [1:0]                 lsw;
        logic [1:0]                 rsw;
        logic                       rx_fresh;
        logic                       fb_fresh;
    } t_joint_reading;

    typedef struct {
        logic [JIDX_W-1:0]          joint;
        logic signed [TORQUE_W-1:0] torque;
        logic                       enable;
        logic [1:0]                 hold;
        logic                       last;
    } t_torque_cmd;

    typedef enum int {
        FLAW_NONE, FLAW_FAULT, FLAW_ZERO_RATING, FLAW_OFF_WINDOW, FLAW_OVERSPEED,
        FLAW_MOTOR_STOPPED, FLAW_STEP_JUMP, FLAW_WILD_ANGLE
    } t_flaw;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   push;
    logic                   full;
    logic [JIDX_W-1:0]      i_joint_index;
    logic [ANGLE_W-1:0]     i_joint_angle;
    logic [SPEED_W-1:0]     i_joint_speed;
    logic [RATING_W-1:0]    i_torque_rating;
    logic                   i_joint_fault;
    logic                   i_joint_running;
    logic [1:0]             i_left_switch;
    logic [1:0]             i_right_switch;
    logic                   i_receiver_fresh;
    logic                   i_feedback_fresh;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [JIDX_W-1:0]      o_out_joint;
    logic signed [TORQUE_W-1:0] o_torque_command;
    logic                   o_drive_enable;
    logic [1:0]             o_hold_state;
    logic                   o_last_of_tick;

    // predictor copy of the registers and the interlock state
    t_cfg   model_cfg;
    logic   armed;
    logic   prev_valid;
    longint prev_angle [JOINT_COUNT];
    longint held_angle [JOINT_COUNT];
    longint held_speed [JOINT_COUNT];
    longint held_rating [JOINT_COUNT];
    logic   held_fault [JOINT_COUNT];
    logic   held_running [JOINT_COUNT];

    t_torque_cmd pending_cmds [$];
    int error_count = 0;
    int items_sent = 0;
    int sender_idle_pct = 20;
    int receiver_stall_pct = 20;

    always #10 i_clk = ~i_clk;

    leg_joint_hold_interlock_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_joint_index    (i_joint_index),
        .i_joint_angle    (i_joint_angle),
        .i_joint_speed    (i_joint_speed),
        .i_torque_rating  (i_torque_rating),
        .i_joint_fault    (i_joint_fault),
        .i_joint_running  (i_joint_running),
        .i_left_switch    (i_left_switch),
        .i_right_switch   (i_right_switch),
        .i_receiver_fresh (i_receiver_fresh),
        .i_feedback_fresh (i_feedback_fresh),
        .empty            (empty),
        .pop              (pop),
        .o_out_joint      (o_out_joint),
        .o_torque_command (o_torque_command),
        .o_drive_enable   (o_drive_enable),
        .o_hold_state     (o_hold_state),
        .o_last_of_tick   (o_last_of_tick)
    );

    function automatic longint joint_ref(int j);
        logic [ANGLE_W-1:0] bits;
        case (j)
            0:       bits = model_cfg.left_ref[23:0];
            1:       bits = model_cfg.left_ref[47:24];
            2:       bits = model_cfg.right_ref[23:0];
            default: bits = model_cfg.right_ref[47:24];
        endcase
        return longint'($signed(bits));
    endfunction

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] clamp_angle(longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic longint rand_span(longint n);
        return longint'($urandom_range(0, 2 * n)) - n;
    endfunction

    // store one reading; a closing reading yields four torque commands
    task automatic predict_joint_reading(input t_joint_reading s);
        int     j;
        logic   mid;
        logic   bad;
        logic   all_running;
        logic   en;
        logic [1:0] hold;
        longint err;
        longint pd;
        longint tq;
        longint lim;
        longint torque [JOINT_COUNT];
        t_torque_cmd c;

        j = int'(s.joint);
        held_angle[j]   = longint'(s.angle);
        held_speed[j]   = longint'(s.speed);
        held_rating[j]  = longint'(s.rating);
        held_fault[j]   = s.fault;
        held_running[j] = s.running;
        if (j != JOINT_COUNT - 1)
            return;

        foreach (torque[i])
            torque[i] = 0;
        en = 1'b0;
        hold = HOLD_IDLE;

        if (s.lsw == SW_DOWN && s.rsw == SW_DOWN) begin
            armed = s.rx_fresh;
            prev_valid = 1'b0;
        end else begin
            mid = (s.lsw == SW_MIDDLE && s.rsw == SW_MIDDLE);
            if (!mid)
                armed = 1'b0;
            if (!armed || !mid || !s.rx_fresh || !s.fb_fresh) begin
                if (!s.rx_fresh || !s.fb_fresh)
                    armed = 1'b0;
                prev_valid = 1'b0;
            end else begin
                bad = 1'b0;
                for (int i = 0; i < JOINT_COUNT; i++) begin
                    if (held_rating[i] == 0 || held_fault[i]
                        || mag(held_angle[i] - joint_ref(i)) > longint'(model_cfg.window)
                        || (prev_valid && mag(held_angle[i] - prev_angle[i])
                            > longint'(model_cfg.step_limit))
                        || mag(held_speed[i]) > longint'(model_cfg.speed_limit))
                        bad = 1'b1;
                end
                if (bad) begin
                    armed = 1'b0;
                    prev_valid = 1'b0;
                end else begin
                    for (int i = 0; i < JOINT_COUNT; i++)
                        prev_angle[i] = held_angle[i];
                    prev_valid = 1'b1;
                    en = 1'b1;
                    all_running = 1'b1;
                    for (int i = 0; i < JOINT_COUNT; i++)
                        if (!held_running[i])
                            all_running = 1'b0;
                    if (!all_running) begin
                        hold = HOLD_ENABLED;
                    end else begin
                        hold = HOLD_HOLDING;
                        for (int i = 0; i < JOINT_COUNT; i++) begin
                            err = joint_ref(i) - held_angle[i];
                            pd = longint'(model_cfg.kp) * err
                                - longint'(model_cfg.kd) * held_speed[i] * 16;
                            // Q.20 to Q.10, round half up
                            tq = (pd + 512) >>> 10;
                            lim = longint'(model_cfg.hold_limit);
                            if (held_rating[i] < lim)
                                lim = held_rating[i];
                            if (tq > lim)
                                tq = lim;
                            if (tq < -lim)
                                tq = -lim;
                            torque[i] = tq;
                        end
                    end
                end
            end
        end

        for (int i = 0; i < JOINT_COUNT; i++) begin
            c.joint  = i[JIDX_W-1:0];
            c.torque = torque[i][TORQUE_W-1:0];
            c.enable = en;
            c.hold   = hold;
            c.last   = (i == JOINT_COUNT - 1);
            pending_cmds.push_back(c);
        end
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        error_count++;
    endtask

    // result side: random pop stalls, every accepted transaction checked in order
    always @(posedge i_clk) begin
        t_torque_cmd w;
        if (i_rst_n && pop && !empty) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result: joint %0d torque %0d", $time,
                         o_out_joint, o_torque_command);
                error_count++;
            end else begin
                w = pending_cmds.pop_front();
                if (o_out_joint !== w.joint)
                    note_mismatch("out_joint", w.joint, o_out_joint);
                if (o_torque_command !== w.torque)
                    note_mismatch("torque_command", w.torque, o_torque_command);
                if (o_drive_enable !== w.enable)
                    note_mismatch("drive_enable", w.enable, o_drive_enable);
                if (o_hold_state !== w.hold)
                    note_mismatch("hold_state", w.hold, o_hold_state);
                if (o_last_of_tick !== w.last)
                    note_mismatch("last_of_tick", w.last, o_last_of_tick);
            end
        end
        pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic send_reading(input t_joint_reading s);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_joint_index    <= s.joint;
        i_joint_angle    <= s.angle;
        i_joint_speed    <= s.speed;
        i_torque_rating  <= s.rating;
        i_joint_fault    <= s.fault;
        i_joint_running  <= s.running;
        i_left_switch    <= s.lsw;
        i_right_switch   <= s.rsw;
        i_receiver_fresh <= s.rx_fresh;
        i_feedback_fresh <= s.fb_fresh;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        predict_joint_reading(s);
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    // idle the block before any register write
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        settle();
        write_reg(CFG_LEFT_REF, c.left_ref);
        write_reg(CFG_RIGHT_REF, c.right_ref);
        write_reg(CFG_KP, CFG_DATA_W'(c.kp));
        write_reg(CFG_KD, CFG_DATA_W'(c.kd));
        write_reg(CFG_HOLD_LIMIT, CFG_DATA_W'(c.hold_limit));
        write_reg(CFG_WINDOW, CFG_DATA_W'(c.window));
        write_reg(CFG_SPEED_LIM, CFG_DATA_W'(c.speed_limit));
        write_reg(CFG_STEP_LIM, CFG_DATA_W'(c.step_limit));
        i_cfg_we <= 1'b0;
        model_cfg = c;
    endtask

    // a reading that passes every check, close enough to its last angle too
    function automatic t_joint_reading good_reading(int j);
        t_joint_reading s;
        longint reach;
        reach = longint'(model_cfg.step_limit) / 2;
        if (longint'(model_cfg.window) < reach)
            reach = longint'(model_cfg.window);
        s.joint    = j[JIDX_W-1:0];
        s.angle    = clamp_angle(joint_ref(j) + rand_span(reach));
        s.speed    = SPEED_W'(rand_span(longint'(model_cfg.speed_limit)));
        s.rating   = ($urandom_range(0, 1) != 0) ? RATING_W'($urandom_range(1, 600))
                                                 : RATING_W'($urandom_range(1, 65535));
        s.fault    = 1'b0;
        s.running  = 1'b1;
        s.lsw      = 2'($urandom_range(0, 3));
        s.rsw      = 2'($urandom_range(0, 3));
        s.rx_fresh = 1'($urandom_range(0, 1));
        s.fb_fresh = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic t_joint_reading noise_reading();
        t_joint_reading s;
        s.joint    = JIDX_W'($urandom);
        s.angle    = ANGLE_W'($urandom);
        s.speed    = SPEED_W'($urandom);
        s.rating   = RATING_W'($urandom);
        s.fault    = 1'($urandom);
        s.running  = 1'($urandom);
        s.lsw      = 2'($urandom);
        s.rsw      = 2'($urandom);
        s.rx_fresh = 1'($urandom);
        s.fb_fresh = 1'($urandom);
        return s;
    endfunction

    function automatic t_joint_reading add_flaw(t_joint_reading s, t_flaw flaw);
        longint gap;
        longint v;
        int j;
        j = int'(s.joint);
        gap = longint'(model_cfg.window) + 1 + longint'($urandom_range(0, 100));
        case (flaw)
            FLAW_FAULT:         s.fault = 1'b1;
            FLAW_ZERO_RATING:   s.rating = '0;
            FLAW_OFF_WINDOW:    s.angle = clamp_angle(joint_ref(j)
                                    + (($urandom_range(0, 1) != 0) ? gap : -gap));
            FLAW_OVERSPEED: begin
                v = longint'($urandom_range(32768, int'(model_cfg.speed_limit) + 1));
                s.speed = SPEED_W'(($urandom_range(0, 1) != 0) ? -v : v);
            end
            FLAW_MOTOR_STOPPED: s.running = 1'b0;
            FLAW_STEP_JUMP:     s.angle = clamp_angle(prev_angle[j]
                                    + longint'(model_cfg.step_limit) + 1);
            FLAW_WILD_ANGLE:    s.angle = ANGLE_W'($urandom);
            default: ;
        endcase
        return s;
    endfunction

    // four readings in joint order; the closing one carries the switch and link bits
    task automatic send_tick(input logic [1:0] lsw, input logic [1:0] rsw,
                             input logic rx_fresh, input logic fb_fresh, input t_flaw flaw);
        t_joint_reading s;
        int flawed;
        flawed = $urandom_range(0, JOINT_COUNT - 1);
        for (int j = 0; j < JOINT_COUNT; j++) begin
            s = good_reading(j);
            if (j == flawed)
                s = add_flaw(s, flaw);
            if (j == JOINT_COUNT - 1) begin
                s.lsw = lsw;
                s.rsw = rsw;
                s.rx_fresh = rx_fresh;
                s.fb_fresh = fb_fresh;
            end
            send_reading(s);
        end
    endtask

    // arm, then a run of hold ticks, with stray readings mixed in
    task automatic run_traffic(input int count, input bit pause_once);
        int target;
        int paused_at;
        t_flaw flaw;
        logic [1:0] lsw;
        logic [1:0] rsw;
        target = items_sent + count;
        paused_at = items_sent + count / 2;
        while (items_sent < target) begin
            if (pause_once && items_sent >= paused_at) begin
                wait_drained();
                pause_once = 1'b0;
            end
            if ($urandom_range(0, 99) < 8) begin
                send_reading(noise_reading());
            end else begin
                send_tick(SW_DOWN, SW_DOWN, $urandom_range(0, 9) != 0, 1'($urandom),
                          FLAW_NONE);
                repeat ($urandom_range(1, 6)) begin
                    flaw = ($urandom_range(0, 99) < 80) ? FLAW_NONE
                                                       : t_flaw'($urandom_range(1, 7));
                    lsw = SW_MIDDLE;
                    rsw = SW_MIDDLE;
                    if ($urandom_range(0, 99) < 15) begin
                        lsw = 2'($urandom);
                        rsw = 2'($urandom);
                    end
                    send_tick(lsw, rsw, $urandom_range(0, 19) != 0,
                              $urandom_range(0, 19) != 0, flaw);
                end
            end
        end
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        c.left_ref    = 48'({$urandom, $urandom});
        c.right_ref   = 48'({$urandom, $urandom});
        c.kp          = 16'($urandom);
        c.kd          = 16'($urandom);
        c.hold_limit  = 15'($urandom_range(1, 32767));
        c.window      = 23'($urandom_range(1, 4000));
        c.speed_limit = 15'($urandom_range(1, 32767));
        c.step_limit  = 23'($urandom_range(1, 4000));
        return c;
    endfunction

    task automatic test_directed_ticks();
        t_joint_reading s;
        // field extremes, closed with both switches down and a stale receiver
        s = good_reading(0);
        s.angle = 24'sh7FFFFF; s.speed = 16'sh7FFF; s.rating = 16'hFFFF; s.fault = 1'b1;
        s.lsw = 2'd3; s.rsw = 2'd3;
        send_reading(s);
        s = good_reading(1);
        s.angle = 24'sh800000; s.speed = 16'sh8000; s.rating = '0; s.running = 1'b0;
        s.lsw = 2'd0; s.rsw = 2'd0;
        send_reading(s);
        s = good_reading(2);
        s.angle = '0; s.speed = '0; s.rating = 16'd1;
        send_reading(s);
        s = good_reading(3);
        s.angle = -24'sd1; s.speed = -16'sd1; s.rating = 16'hFFFF;
        s.lsw = SW_DOWN; s.rsw = SW_DOWN; s.rx_fresh = 1'b0; s.fb_fresh = 1'b1;
        send_reading(s);

        send_tick(SW_DOWN, SW_DOWN, 1'b1, 1'b1, FLAW_NONE);
        send_tick(SW_MIDDLE, SW_MIDDLE, 1'b1, 1'b1, FLAW_NONE);
        send_tick(SW_MIDDLE, SW_MIDDLE, 1'b1, 1'b1, FLAW_MOTOR_STOPPED);
        send_tick(SW_MIDDLE, SW_MIDDLE, 1'b1, 1'b1, FLAW_STEP_JUMP);
        send_tick(SW_DOWN, SW_DOWN, 1'b1, 1'b1, FLAW_NONE);
        send_tick(SW_MIDDLE, SW_MIDDLE, 1'b1, 1'b0, FLAW_NONE);
    endtask

    task automatic test_random_settings();
        apply_settings(random_settings());
        run_traffic(150, 1'b1);
    endtask

    task automatic test_widest_settings();
        t_cfg c;
        c.left_ref    = '1;
        c.right_ref   = {24'sh800000, 24'sh7FFFFF};
        c.kp          = 16'hFFFF;
        c.kd          = 16'hFFFF;
        c.hold_limit  = 15'h7FFF;
        c.window      = 23'h7FFFFF;
        c.speed_limit = 15'h7FFF;
        c.step_limit  = 23'h7FFFFF;
        apply_settings(c);
        run_traffic(100, 1'b0);
    endtask

    task automatic test_narrowest_settings();
        t_cfg c;
        c.left_ref    = {24'sh800000, 24'sh800000};
        c.right_ref   = {24'sh7FFFFF, 24'sh000000};
        c.kp          = '0;
        c.kd          = '0;
        c.hold_limit  = 15'd1;
        c.window      = 23'd1;
        c.speed_limit = 15'd1;
        c.step_limit  = 23'd1;
        apply_settings(c);
        run_traffic(80, 1'b0);
    endtask

    // long stretch with both sides always ready
    task automatic test_full_rate();
        apply_settings(random_settings());
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        run_traffic(140, 1'b0);
        sender_idle_pct = 20;
        receiver_stall_pct = 20;
    endtask

    initial begin
        int waited;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_LEFT_REF;
        i_cfg_data       <= '0;
        push             <= 1'b0;
        i_joint_index    <= '0;
        i_joint_angle    <= '0;
        i_joint_speed    <= '0;
        i_torque_rating  <= '0;
        i_joint_fault    <= 1'b0;
        i_joint_running  <= 1'b0;
        i_left_switch    <= '0;
        i_right_switch   <= '0;
        i_receiver_fresh <= 1'b0;
        i_feedback_fresh <= 1'b0;

        model_cfg.left_ref    = '0;
        model_cfg.right_ref   = '0;
        model_cfg.kp          = 16'd1024;
        model_cfg.kd          = 16'd64;
        model_cfg.hold_limit  = 15'd512;
        model_cfg.window      = 23'd205;
        model_cfg.speed_limit = 15'd102;
        model_cfg.step_limit  = 23'd164;
        armed = 1'b0;
        prev_valid = 1'b0;
        foreach (prev_angle[i])
            prev_angle[i] = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ticks();
        test_random_settings();
        test_widest_settings();
        test_narrowest_settings();
        test_full_rate();

        push <= 1'b0;
        waited = 0;
        while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_cmds.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_cmds.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(64'd20_000_000);
        $display("%0t: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
